/* sv/ipt_pkg.sv */
// Shared types, microcode encoding and constants for the parity/prime test block.
package ipt_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int UADDR_W        = 4;

    typedef logic [UADDR_W-1:0] uaddr_t;

    // Microcode step addresses
    localparam uaddr_t U_IDLE       = 4'd0;
    localparam uaddr_t U_CHECK      = 4'd1;
    localparam uaddr_t U_LOOP_TEST  = 4'd2;
    localparam uaddr_t U_DIV_INIT   = 4'd3;
    localparam uaddr_t U_DIV_STEP   = 4'd4;
    localparam uaddr_t U_REM_TEST   = 4'd5;
    localparam uaddr_t U_NEXT_DIV   = 4'd6;
    localparam uaddr_t U_DONE_PRIME = 4'd7;
    localparam uaddr_t U_DONE_NOT   = 4'd8;

    // Jump condition: jump to target when true, else fall through
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_SMALL,
        C_SQ_GT,
        C_CNT_NZ,
        C_REM_ZERO
    } cond_t;

    typedef struct packed {
        cond_t  cond;
        uaddr_t target;
        logic   load;
        logic   div_init;
        logic   div_step;
        logic   next_div;
        logic   finish;
        logic   prime_val;
    } ctrl_word_t;

    typedef struct packed {
        logic start;
        logic below_two;
        logic sq_gt;
        logic cnt_nz;
        logic rem_zero;
    } status_t;

endpackage

/* sv/integer_parity_prime_test_top.sv */
// Top level of the parity / primality / equality classifier.
// A request is taken when start is high while busy is low. The result flags appear
// on is_even, is_odd, is_prime and is_equal for one cycle with done high; the
// receiver cannot stall them, and they are not repeated. A microcoded sequencer
// runs trial division with a bit-serial remainder unit that takes one bit of the
// number at a time for each trial divisor. Values below two, and values with the
// top bit set, finish without trial division; otherwise each trial divisor adds
// a full remainder pass.
// A new request can be taken in the cycle that done is shown.
module integer_parity_prime_test_top
    import ipt_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [DATA_WIDTH-1:0] number,
    input  logic [DATA_WIDTH-1:0] other_value,
    output logic                  done,
    output logic                  is_even,
    output logic                  is_odd,
    output logic                  is_prime,
    output logic                  is_equal
);

    ctrl_word_t ctrl;
    status_t    status;

    ipt_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    ipt_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .start       (start),
        .number      (number),
        .other_value (other_value),
        .status      (status),
        .done        (done),
        .is_even     (is_even),
        .is_odd      (is_odd),
        .is_prime    (is_prime),
        .is_equal    (is_equal)
    );

endmodule

/* sv/ipt_ucode_rom.sv */
// Microcode ROM: one control word per sequencer step.
module ipt_ucode_rom
    import ipt_pkg::*;
(
    input  uaddr_t     addr,
    output ctrl_word_t word
);

    always_comb
    begin
        word = '0;
        word.cond   = C_NEVER;
        word.target = U_IDLE;
        unique case (addr)
            U_IDLE:
            begin
                word.load   = 1'b1;
                word.cond   = C_NO_START;
                word.target = U_IDLE;
            end
            U_CHECK:
            begin
                word.cond   = C_SMALL;
                word.target = U_DONE_NOT;
            end
            U_LOOP_TEST:
            begin
                word.cond   = C_SQ_GT;
                word.target = U_DONE_PRIME;
            end
            U_DIV_INIT:
            begin
                word.div_init = 1'b1;
            end
            U_DIV_STEP:
            begin
                word.div_step = 1'b1;
                word.cond     = C_CNT_NZ;
                word.target   = U_DIV_STEP;
            end
            U_REM_TEST:
            begin
                word.cond   = C_REM_ZERO;
                word.target = U_DONE_NOT;
            end
            U_NEXT_DIV:
            begin
                word.next_div = 1'b1;
                word.cond     = C_ALWAYS;
                word.target   = U_LOOP_TEST;
            end
            U_DONE_PRIME:
            begin
                word.finish    = 1'b1;
                word.prime_val = 1'b1;
                word.cond      = C_ALWAYS;
                word.target    = U_IDLE;
            end
            U_DONE_NOT:
            begin
                word.finish = 1'b1;
                word.cond   = C_ALWAYS;
                word.target = U_IDLE;
            end
            default:
            begin
                word.cond   = C_ALWAYS;
                word.target = U_IDLE;
            end
        endcase
    end

endmodule

/* sv/ipt_sequencer.sv */
// Step counter with conditional jumps driven by the microcode ROM.
module ipt_sequencer
    import ipt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  status_t    status,
    output ctrl_word_t ctrl,
    output logic       busy
);

    uaddr_t     upc_reg;
    uaddr_t     upc_next;
    ctrl_word_t rom_word;
    logic       take_jump;

    ipt_ucode_rom u_rom (
        .addr (upc_reg),
        .word (rom_word)
    );

    always_comb
    begin
        unique case (rom_word.cond)
            C_NEVER:    take_jump = 1'b0;
            C_ALWAYS:   take_jump = 1'b1;
            C_NO_START: take_jump = !status.start;
            C_SMALL:    take_jump = status.below_two;
            C_SQ_GT:    take_jump = status.sq_gt;
            C_CNT_NZ:   take_jump = status.cnt_nz;
            C_REM_ZERO: take_jump = status.rem_zero;
            default:    take_jump = 1'b0;
        endcase
        upc_next = take_jump ? rom_word.target : upc_reg + uaddr_t'(1);

        // a request is only loaded when it is actually taken
        ctrl      = rom_word;
        ctrl.load = rom_word.load & status.start;
    end

    assign busy = (upc_reg != U_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= U_IDLE;
        else
            upc_reg <= upc_next;
    end

endmodule

/* sv/ipt_datapath.sv */
// Datapath: operand hold, divisor/square tracking, bit-serial remainder, result flags.
module ipt_datapath
    import ipt_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_word_t            ctrl,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] number,
    input  logic [DATA_WIDTH-1:0] other_value,
    output status_t               status,
    output logic                  done,
    output logic                  is_even,
    output logic                  is_odd,
    output logic                  is_prime,
    output logic                  is_equal
);

    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(W);

    logic [W-1:0]  num_reg;
    logic [W-1:0]  div_reg;
    logic [W-1:0]  sq_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  rem_next;
    logic [CW-1:0] bit_reg;
    logic [W:0]    shifted;
    logic          odd_pend_reg;
    logic          eq_pend_reg;
    logic          done_reg;
    logic          even_out_reg;
    logic          odd_out_reg;
    logic          prime_out_reg;
    logic          eq_out_reg;

    // one restoring-division bit per cycle while div_step is set, MSB of the number first
    always_comb
    begin
        shifted = {rem_reg, num_reg[bit_reg]};
        if (shifted >= {1'b0, div_reg})
            rem_next = W'(shifted - {1'b0, div_reg});
        else
            rem_next = shifted[W-1:0];
    end

    always_comb
    begin
        status.start     = start;
        status.below_two = num_reg[W-1] | (num_reg < W'(2));
        status.sq_gt     = sq_reg > num_reg;
        status.cnt_nz    = (bit_reg != '0);
        status.rem_zero  = (rem_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            num_reg      <= number;
            odd_pend_reg <= number[0];
            eq_pend_reg  <= (number == other_value);
            div_reg      <= W'(2);
            sq_reg       <= W'(4);
        end
        if (ctrl.div_init)
        begin
            rem_reg <= '0;
            bit_reg <= CW'(W - 1);
        end
        if (ctrl.div_step)
        begin
            rem_reg <= rem_next;
            if (bit_reg != '0)
                bit_reg <= bit_reg - CW'(1);
        end
        if (ctrl.next_div)
        begin
            // (d+1)^2 = d^2 + 2d + 1
            div_reg <= div_reg + W'(1);
            sq_reg  <= sq_reg + {div_reg[W-2:0], 1'b1};
        end
        if (ctrl.finish)
        begin
            even_out_reg  <= !odd_pend_reg;
            odd_out_reg   <= odd_pend_reg;
            prime_out_reg <= ctrl.prime_val;
            eq_out_reg    <= eq_pend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctrl.finish;
    end

    assign done     = done_reg;
    assign is_even  = even_out_reg;
    assign is_odd   = odd_out_reg;
    assign is_prime = prime_out_reg;
    assign is_equal = eq_out_reg;

endmodule

/* tb/tb_integer_parity_prime_test_top.sv */
// Testbench for the parity / primality / equality classifier: scoreboard, driver and checks.
`timescale 1ns / 1ps

typedef logic [ipt_pkg::DATA_WIDTH_DEF-1:0] word_t;

typedef struct packed {
    logic  is_even;
    logic  is_odd;
    logic  is_prime;
    logic  is_equal;
    word_t last_div;
    word_t last_rem;
} verdict_t;

class prime_scoreboard;
    word_t       trial_divisor;
    word_t       partial_remainder;
    word_t       held_number;
    verdict_t    awaited[$];
    int unsigned errors;

    function new();
        trial_divisor     = '0;
        partial_remainder = '0;
        held_number       = '0;
        errors            = 0;
    endfunction

    // Pure: flags for one request plus the last divisor tried and its remainder.
    function verdict_t classify(word_t num, word_t oth);
        verdict_t v;
        word_t    d;
        word_t    r;
        logic     prime;
        v          = '0;
        v.is_even  = ~num[0];
        v.is_odd   = num[0];
        v.is_equal = (num == oth);
        if (num[$bits(word_t)-1] || num < 2) begin
            v.is_prime = 1'b0;
        end
        else begin
            prime = 1'b1;
            d     = 2;
            while (prime && d <= num / d) begin
                r          = num % d;
                v.last_div = d;
                v.last_rem = r;
                if (r == 0)
                    prime = 1'b0;
                else
                    d = d + 1;
            end
            v.is_prime = prime;
        end
        return v;
    endfunction

    function void note_request(word_t num, word_t oth);
        verdict_t v;
        v                 = classify(num, oth);
        held_number       = num;
        trial_divisor     = v.last_div;
        partial_remainder = v.last_rem;
        awaited.push_back(v);
    endfunction

    function void compare_flag(string field, logic exp_val, logic act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s mismatch: expected %b, got %b", $time, field, exp_val, act_val);
            errors++;
        end
    endfunction

    function void check_result(logic even_f, logic odd_f, logic prime_f, logic equal_f);
        verdict_t v;
        if (awaited.size() == 0) begin
            $display("%0t: unexpected result: expected none, got even=%b odd=%b prime=%b equal=%b",
                     $time, even_f, odd_f, prime_f, equal_f);
            errors++;
            return;
        end
        v = awaited.pop_front();
        compare_flag("is_even", v.is_even, even_f);
        compare_flag("is_odd", v.is_odd, odd_f);
        compare_flag("is_prime", v.is_prime, prime_f);
        compare_flag("is_equal", v.is_equal, equal_f);
    endfunction

    function int unsigned pending();
        return awaited.size();
    endfunction
endclass

module tb_integer_parity_prime_test_top;
    import ipt_pkg::*;

    localparam int          W           = DATA_WIDTH_DEF;
    localparam int unsigned STALL_LIMIT = 1_000_000;
    localparam int unsigned COST_CAP    = 400;   // max divisor for random full-range values
    localparam int          PER_PHASE   = 34;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    word_t number;
    word_t other_value;
    logic  done;
    logic  is_even;
    logic  is_odd;
    logic  is_prime;
    logic  is_equal;

    prime_scoreboard sb;
    int unsigned     quiet_cycles;
    int              idle_pct;
    int              phase_pct [3] = '{0, 77, 21};

    integer_parity_prime_test_top #(.DATA_WIDTH(W)) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .number     (number),
        .other_value(other_value),
        .done       (done),
        .is_even    (is_even),
        .is_odd     (is_odd),
        .is_prime   (is_prime),
        .is_equal   (is_equal)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Result checking and stall watchdog
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (done)
                sb.check_result(is_even, is_odd, is_prime, is_equal);
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_integer_parity_prime_test_top: done, errors");
                $finish;
            end
        end
    end

    task automatic send_request(word_t num, word_t oth);
        @(negedge clk);
        start       <= 1'b1;
        number      <= num;
        other_value <= oth;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(num, oth);
    endtask

    task automatic sender_gap();
        if ($urandom_range(99) < idle_pct) begin
            @(negedge clk);
            start       <= 1'b0;
            number      <= $urandom;
            other_value <= $urandom;
            while ($urandom_range(99) < idle_pct)
                @(negedge clk);
        end
    endtask

    // Hold off new requests until every pending result is back
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic word_t pick_number();
        word_t       v;
        verdict_t    probe;
        int unsigned kind;
        kind = $urandom_range(99);
        if (kind < 30) begin
            v = $urandom_range(4095);
        end
        else if (kind < 45) begin
            v        = $urandom;
            v[W-1]   = 1'b1;
        end
        else if (kind < 55) begin
            v = $urandom_range(1 << 20, 1 << 12);
        end
        else begin
            v     = $urandom;
            probe = sb.classify(v, v);
            // long trial runs are cut short: an even value stops at the first divisor
            if (probe.last_div > COST_CAP)
                v[0] = 1'b0;
        end
        return v;
    endfunction

    function automatic word_t pick_other(word_t num);
        int unsigned kind;
        kind = $urandom_range(9);
        if (kind < 4)
            return num;
        else if (kind < 6)
            return num ^ (word_t'(1) << $urandom_range(W-1));
        else
            return $urandom;
    endfunction

    initial
    begin
        word_t num;
        start        = 1'b0;
        number       = '0;
        other_value  = '0;
        rst_n        = 1'b0;
        idle_pct     = 0;
        quiet_cycles = 0;
        sb           = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: values below two, two, small squares, negatives, field extremes
        send_request(32'd0, 32'd0);
        send_request(32'd1, 32'd1);
        send_request(32'd1, 32'd0);
        send_request(32'd2, 32'd2);
        send_request(32'd3, 32'd0);
        send_request(32'd4, 32'd4);
        send_request(32'd9, 32'd9);
        send_request(32'd25, 32'd24);
        send_request(32'd49, 32'd49);
        send_request(32'd91, 32'd91);
        send_request(32'd97, 32'd97);
        send_request(32'd65521, 32'd0);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFD, 32'd3);
        send_request(32'h8000_0000, 32'h8000_0000);
        send_request(32'h8000_0000, 32'h7FFF_FFFF);
        send_request(32'h7FFF_FFFE, 32'h7FFF_FFFE);
        send_request(32'h7FFF_FFFD, 32'h8000_0000);
        send_request(32'h5555_5555, 32'hAAAA_AAAA);
        send_request(32'hAAAA_AAAA, 32'h5555_5555);
        send_request(32'd16777213, 32'd16777213);
        drain();

        foreach (phase_pct[p]) begin
            idle_pct = phase_pct[p];
            for (int i = 0; i < PER_PHASE; i++) begin
                num = pick_number();
                send_request(num, pick_other(num));
                sender_gap();
            end
            drain();
        end

        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_integer_parity_prime_test_top: done, clean");
        else
            $display("tb_integer_parity_prime_test_top: done, errors");
        $finish;
    end

endmodule
